// ===== design/mhpq_pkg.sv =====
// Shared types and constants for the min-heap priority queue.
// No dependencies.
`default_nettype none

package mhpq_pkg;

    localparam int KEY_W            = 32;
    localparam int IN_TAG_W         = 16;
    localparam int OUT_CNT_W        = 8;
    localparam int DEF_CAPACITY     = 128;
    localparam int DEF_TAG_BITS     = 16;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [KEY_W-1:0]    key;
        logic [IN_TAG_W-1:0] tag;
    } in_item_t;

    typedef struct packed {
        logic                 ok;
        logic [KEY_W-1:0]     min_key;
        logic [IN_TAG_W-1:0]  min_tag;
        logic [OUT_CNT_W-1:0] count;
        logic                 is_empty;
        logic                 is_full;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IN_CHK,
        ST_IN_CMP,
        ST_RM_ROOT,
        ST_RM_LAST,
        ST_RM_MOVE,
        ST_SD_CHK,
        ST_SD_RDL,
        ST_SD_SEL,
        ST_SD_CMP,
        ST_DONE
    } st_t;

endpackage

`default_nettype wire

// ===== design/mhpq_ram.sv =====
// Entry store: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module mhpq_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 48
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/min_heap_priority_queue.sv =====
// Binary min-heap priority queue top level: sequencer, shared key compare, output register.
// Depends on mhpq_pkg and mhpq_ram.
// Clear, invalid or failed ops go straight to the result; insert rises and remove sinks level
// by level until a compare stops it or the root or a leaf is reached.
// One item at a time, next taken after the result loads.
// Reset (aresetn low, synchronous) clears the count and handshake state; the store is not cleared.
`default_nettype none

module min_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int TAG_BITS = DEF_TAG_BITS
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = AW + 2;
    localparam int DW    = KEY_W + TAG_BITS;

    st_t state_reg, state_next;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [AW-1:0]       ch_pos_reg, ch_pos_next;
    logic [KEY_W-1:0]    k_reg, k_next;
    logic [TAG_BITS-1:0] t_reg, t_next;
    logic [KEY_W-1:0]    ch_key_reg, ch_key_next;
    logic [TAG_BITS-1:0] ch_tag_reg, ch_tag_next;
    logic [KEY_W-1:0]    mk_reg, mk_next;
    logic [TAG_BITS-1:0] mt_reg, mt_next;
    logic                ok_reg, ok_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_item_reg, m_item_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [DW-1:0]       ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [DW-1:0]       ram_rdata;
    logic [KEY_W-1:0]    rd_key;
    logic [TAG_BITS-1:0] rd_tag;

    logic [KEY_W-1:0]    cmp_a, cmp_b;
    logic                cmp_le;

    logic                accept;
    logic                is_full_now;
    logic [AW-1:0]       parent;
    logic [CW-1:0]       left_c;
    logic                no_child;
    logic                has_right;
    logic                out_free;

    mhpq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key      = ram_rdata[DW-1:TAG_BITS];
    assign rd_tag      = ram_rdata[TAG_BITS-1:0];
    assign accept      = s_valid && s_ready;
    assign is_full_now = (count_reg == CNT_W'(CAPACITY));
    assign parent      = (pos_reg - AW'(1)) >> 1;
    assign left_c      = (CW'(pos_reg) << 1) + CW'(1);
    assign no_child    = (left_c >= CW'(count_reg));
    assign has_right   = ((CW'(ch_pos_reg) + CW'(1)) < CW'(count_reg));
    assign out_free    = !m_valid_reg || m_ready;
    assign cmp_le      = (cmp_a <= cmp_b);

    always_comb begin
        case (state_reg)
            ST_IN_CMP: begin
                cmp_a = rd_key;
                cmp_b = k_reg;
            end
            ST_SD_SEL: begin
                cmp_a = ch_key_reg;
                cmp_b = rd_key;
            end
            default: begin
                cmp_a = k_reg;
                cmp_b = ch_key_reg;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_item.cmd == CMD_INSERT && !is_full_now) begin
                        state_next = ST_IN_CHK;
                    end else if (s_item.cmd == CMD_REMOVE && count_reg != '0) begin
                        state_next = ST_RM_ROOT;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_IN_CHK: state_next = (pos_reg == '0) ? ST_DONE : ST_IN_CMP;
            ST_IN_CMP: state_next = cmp_le ? ST_DONE : ST_IN_CHK;
            ST_RM_ROOT: state_next = ST_RM_LAST;
            ST_RM_LAST: state_next = ST_RM_MOVE;
            ST_RM_MOVE: state_next = ST_SD_CHK;
            ST_SD_CHK: state_next = no_child ? ST_DONE : ST_SD_RDL;
            ST_SD_RDL: state_next = has_right ? ST_SD_SEL : ST_SD_CMP;
            ST_SD_SEL: state_next = ST_SD_CMP;
            ST_SD_CMP: state_next = cmp_le ? ST_DONE : ST_SD_CHK;
            ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        count_next   = count_reg;
        pos_next     = pos_reg;
        ch_pos_next  = ch_pos_reg;
        k_next       = k_reg;
        t_next       = t_reg;
        ch_key_next  = ch_key_reg;
        ch_tag_next  = ch_tag_reg;
        mk_next      = mk_reg;
        mt_next      = mt_reg;
        ok_next      = ok_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        s_ready      = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = pos_reg;
        ram_wdata    = {k_reg, t_reg};
        ram_raddr    = parent;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    mk_next = '0;
                    mt_next = '0;
                    k_next  = s_item.key;
                    t_next  = TAG_BITS'(s_item.tag);
                    case (s_item.cmd)
                        CMD_INSERT: begin
                            ok_next = !is_full_now;
                            if (!is_full_now) begin
                                pos_next   = AW'(count_reg);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_REMOVE: ok_next = (count_reg != '0);
                        CMD_CLEAR: begin
                            ok_next    = 1'b1;
                            count_next = '0;
                        end
                        default: ok_next = 1'b0;
                    endcase
                end
            end
            ST_IN_CHK: begin
                if (pos_reg == '0) begin
                    ram_we = 1'b1;
                end
            end
            ST_IN_CMP: begin
                ram_we = 1'b1;
                if (!cmp_le) begin
                    ram_wdata = ram_rdata;
                    pos_next  = parent;
                end
            end
            ST_RM_ROOT: begin
                ram_raddr  = '0;
                count_next = count_reg - CNT_W'(1);
            end
            ST_RM_LAST: begin
                ram_raddr = AW'(count_reg);
                mk_next   = rd_key;
                mt_next   = rd_tag;
            end
            ST_RM_MOVE: begin
                k_next   = rd_key;
                t_next   = rd_tag;
                pos_next = '0;
            end
            ST_SD_CHK: begin
                ram_raddr   = AW'(left_c);
                ch_pos_next = AW'(left_c);
                if (no_child) begin
                    ram_we = 1'b1;
                end
            end
            ST_SD_RDL: begin
                ram_raddr   = ch_pos_reg + AW'(1);
                ch_key_next = rd_key;
                ch_tag_next = rd_tag;
            end
            ST_SD_SEL: begin
                if (!cmp_le) begin
                    ch_key_next = rd_key;
                    ch_tag_next = rd_tag;
                    ch_pos_next = ch_pos_reg + AW'(1);
                end
            end
            ST_SD_CMP: begin
                ram_we = 1'b1;
                if (!cmp_le) begin
                    ram_wdata = {ch_key_reg, ch_tag_reg};
                    pos_next  = ch_pos_reg;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_item_next.ok       = ok_reg;
                    m_item_next.min_key  = mk_reg;
                    m_item_next.min_tag  = IN_TAG_W'(mt_reg);
                    m_item_next.count    = OUT_CNT_W'(count_reg);
                    m_item_next.is_empty = (count_reg == '0);
                    m_item_next.is_full  = is_full_now;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        ch_pos_reg <= ch_pos_next;
        k_reg      <= k_next;
        t_reg      <= t_next;
        ch_key_reg <= ch_key_next;
        ch_tag_reg <= ch_tag_next;
        mk_reg     <= mk_next;
        mt_reg     <= mt_next;
        ok_reg     <= ok_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg != ST_IDLE && state_reg != ST_DONE))
        else $error("store written outside an operation");

    a_clear_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_item.cmd == CMD_CLEAR) |=> (state_reg == ST_DONE && count_reg == '0))
        else $error("clear did not empty the heap");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_item.is_empty && m_item.is_full))
        else $error("item flagged empty and full");

endmodule

`default_nettype wire
